### hdl/boc_pkg.sv
// Shared types and constants for the barometric offset calibration block.
// Used by the channel interfaces, the offset divider and the top level.
// No dependencies.
package boc_pkg;

    localparam int WORD_W    = 16;
    localparam int CNT_W     = 9;
    localparam int SUM_W     = 24;
    localparam int ALT_W     = 25;
    localparam int SKIP_W    = 8;
    localparam int SCALE_W   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int AVG_SAMPLES_DEF = 40;

    localparam logic [SKIP_W-1:0]  SKIP_RST    = 8'd20;
    localparam logic [WORD_W-1:0]  FLOOR_RST   = 16'd10;
    localparam logic [WORD_W-1:0]  CEILING_RST = 16'd30000;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP    = 2'd0,
        CFG_FLOOR   = 2'd1,
        CFG_CEILING = 2'd2,
        CFG_SCALE   = 2'd3
    } t_cfg_reg;

    // Per-request information carried down the pipeline.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ok;
        logic              done;
        logic              fix;
    } t_stage;

endpackage

### hdl/boc_in_if.sv
// Request channel of the barometric offset calibration block.
// Depends on boc_pkg.
interface boc_in_if import boc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              bus_idle;
    logic [WORD_W-1:0] raw_sample;

    modport source (output valid, output bus_idle, output raw_sample, input ready);
    modport sink   (input valid, input bus_idle, input raw_sample, output ready);
endinterface

### hdl/boc_out_if.sv
// Result channel of the barometric offset calibration block.
// Depends on boc_pkg.
interface boc_out_if import boc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] altitude_cm;
    logic                    sample_ok;
    logic                    calibrated;
    logic [WORD_W-1:0]       held_sample;

    modport source (output valid, output altitude_cm, output sample_ok,
                    output calibrated, output held_sample, input ready);
    modport sink   (input valid, input altitude_cm, input sample_ok,
                    input calibrated, input held_sample, output ready);
endinterface

### hdl/boc_offset_div.sv
// Averaging divider for the zero offset: sum / AVERAGE_SAMPLES by a registered
// reciprocal multiply, followed by the floor and ceiling clamp. Depends on boc_pkg.
module boc_offset_div import boc_pkg::*; #(
    parameter int AVERAGE_SAMPLES = AVG_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [WORD_W-1:0] i_floor,
    input  logic [WORD_W-1:0] i_ceiling,
    output logic [WORD_W-1:0] o_offset
);

    // With SHIFT = SUM_W + ceil(log2 d) and the reciprocal rounded up, the
    // truncated product equals the exact quotient for every sum below 2^SUM_W.
    localparam int SHIFT   = SUM_W + $clog2(AVERAGE_SAMPLES);
    localparam int RECIP_W = SUM_W + 2;
    localparam int MUL_W   = SUM_W + RECIP_W;
    localparam int PROD_W  = SHIFT + SUM_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

    logic [MUL_W-1:0]  r_prod;
    logic [PROD_W-1:0] prod_ext;
    logic [SUM_W-1:0]  quot;
    logic [SUM_W-1:0]  q_floor;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= MUL_W'(i_sum) * MUL_W'(RECIP);
        end
    end

    always_comb begin
        prod_ext = PROD_W'(r_prod);
        quot     = prod_ext[SHIFT +: SUM_W];
        // The floor is applied first, so the ceiling wins when they cross.
        q_floor  = (quot < SUM_W'(i_floor)) ? SUM_W'(i_floor) : quot;
        if (q_floor > SUM_W'(i_ceiling)) begin
            o_offset = i_ceiling;
        end else begin
            o_offset = q_floor[WORD_W-1:0];
        end
    end

endmodule

### hdl/baro_offset_calibrate_convert.sv
// Barometric altimeter: zero-offset calibration and altitude conversion.
//
// Requests arrive on i_req (bus_idle, raw_sample); one result per request
// leaves on o_res (altitude_cm, sample_ok, calibrated, held_sample). Both
// channels use valid/ready; a request or result moves on a clock edge with
// both high. The configuration port (i_cfg_we, i_cfg_index, i_cfg_data)
// writes skip_samples, offset_floor, offset_ceiling and scale_cm_per_count;
// any write reloads the start-up countdown.
//
// One request is taken every cycle while the receiver takes results; the
// three-stage pipeline (state update with the reciprocal multiply, offset
// clamp, altitude multiply into the result register) carries each request.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_req.ready falls until the result is taken.
//
// The synchronous reset restores the register defaults, holds word zero as a
// valid sample, empties the pipeline and clears the calibration.
module baro_offset_calibrate_convert import boc_pkg::*; #(
    parameter int AVERAGE_SAMPLES = AVG_SAMPLES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    boc_in_if.sink               i_req,
    boc_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [CNT_W-1:0] AVG_CNT = CNT_W'(AVERAGE_SAMPLES);

    // Configuration registers.
    logic [SKIP_W-1:0]  r_skip,    n_skip;
    logic [WORD_W-1:0]  r_floor,   n_floor;
    logic [WORD_W-1:0]  r_ceiling, n_ceiling;
    logic [SCALE_W-1:0] r_scale,   n_scale;

    // Calibration state.
    logic [WORD_W-1:0]  r_word,   n_word;
    logic               r_ok,     n_ok;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;
    logic [SUM_W-1:0]   r_sum,    n_sum;
    logic               r_done,   n_done;
    logic               n_fix;
    logic [WORD_W-1:0]  r_zero_offset;

    // Pipeline.
    logic               r_s1_valid;
    t_stage             r_s1;
    logic               r_s2_valid;
    t_stage             r_s2;
    logic               r_out_valid;
    logic signed [ALT_W-1:0] r_alt;
    logic               r_out_ok;
    logic               r_out_done;
    logic [WORD_W-1:0]  r_out_word;

    logic               advance;
    logic               accept;
    logic               cfg_hit;
    logic [CNT_W-1:0]   cnt_dec;
    logic [WORD_W-1:0]  div_offset;
    logic signed [WORD_W:0]    diff;
    logic signed [ALT_W:0]     alt_full;

    assign advance     = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && advance;
    assign i_req.ready = advance;

    always_comb begin
        n_skip    = r_skip;
        n_floor   = r_floor;
        n_ceiling = r_ceiling;
        n_scale   = r_scale;
        cfg_hit   = 1'b0;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SKIP: begin
                    n_skip  = i_cfg_data[SKIP_W-1:0];
                    cfg_hit = 1'b1;
                end
                CFG_FLOOR: begin
                    n_floor = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                CFG_CEILING: begin
                    n_ceiling = i_cfg_data;
                    cfg_hit   = 1'b1;
                end
                CFG_SCALE: begin
                    n_scale = i_cfg_data[SCALE_W-1:0];
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_word  = r_word;
        n_ok    = r_ok;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_done  = r_done;
        n_fix   = 1'b0;
        cnt_dec = r_cnt - CNT_W'(1);
        if (accept) begin
            if (i_req.bus_idle) begin
                n_word = i_req.raw_sample;
                n_ok   = (i_req.raw_sample != '0);
            end
            if (n_ok && !r_done) begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0) begin
                    // The sum is final here; the divider works on r_sum.
                    n_done = 1'b1;
                    n_fix  = 1'b1;
                end else if (cnt_dec <= AVG_CNT) begin
                    n_sum = r_sum + SUM_W'(n_word);
                end
            end
        end
        if (cfg_hit) begin
            n_cnt = CNT_W'({1'b0, n_skip}) + AVG_CNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip    <= SKIP_RST;
            r_floor   <= FLOOR_RST;
            r_ceiling <= CEILING_RST;
            r_scale   <= SCALE_RST;
            r_word    <= '0;
            r_ok      <= 1'b1;
            r_cnt     <= CNT_W'({1'b0, SKIP_RST}) + AVG_CNT;
            r_sum     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_skip    <= n_skip;
            r_floor   <= n_floor;
            r_ceiling <= n_ceiling;
            r_scale   <= n_scale;
            r_word    <= n_word;
            r_ok      <= n_ok;
            r_cnt     <= n_cnt;
            r_sum     <= n_sum;
            r_done    <= n_done;
        end
    end

    boc_offset_div #(
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_offset_div (
        .i_clk     (i_clk),
        .i_en      (advance),
        .i_sum     (r_sum),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling),
        .o_offset  (div_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_zero_offset <= '0;
        end else if (advance) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            // The request that completes calibration fixes the offset as it
            // moves on, so it and every later request see the new value.
            if (r_s1_valid && r_s1.fix) begin
                r_zero_offset <= div_offset;
            end
        end
    end

    always_comb begin
        diff     = $signed({1'b0, r_zero_offset}) - $signed({1'b0, r_s2.word});
        alt_full = (ALT_W+1)'(diff) * (ALT_W+1)'($signed({1'b0, r_scale}));
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1.word  <= n_word;
            r_s1.ok    <= n_ok;
            r_s1.done  <= n_done;
            r_s1.fix   <= n_fix;
            r_s2       <= r_s1;
            r_out_ok   <= r_s2.ok;
            r_out_done <= r_s2.done;
            r_out_word <= r_s2.word;
            if (r_s2.ok && r_s2.done) begin
                r_alt <= alt_full[ALT_W-1:0];
            end else begin
                r_alt <= '0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.altitude_cm = r_alt;
    assign o_res.sample_ok   = r_out_ok;
    assign o_res.calibrated  = r_out_done;
    assign o_res.held_sample = r_out_word;

endmodule

### verif/baro_offset_calibrate_convert_tb.sv
// Self-checking testbench for baro_offset_calibrate_convert.
// It predicts every result from its own model of the block and checks each one.
// Depends on boc_pkg, boc_in_if, boc_out_if and the block itself.
`timescale 1ns / 100ps

module baro_offset_calibrate_convert_tb import boc_pkg::*; ();

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_CYCLES   = 10;

    typedef struct packed {
        logic [ALT_W-1:0]  altitude;
        logic              ok;
        logic              done;
        logic [WORD_W-1:0] word;
    } t_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    boc_in_if  req_ch ();
    boc_out_if res_ch ();

    baro_offset_calibrate_convert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted block state and register copies.
    logic [SKIP_W-1:0]  skip_q;
    logic [WORD_W-1:0]  floor_q;
    logic [WORD_W-1:0]  ceiling_q;
    logic [SCALE_W-1:0] scale_q;
    logic [WORD_W-1:0]  word_q;
    logic               valid_q;
    logic [CNT_W-1:0]   countdown_q;
    logic [SUM_W-1:0]   sum_q;
    logic [WORD_W-1:0]  offset_q;
    logic               done_q;

    // The counters start at zero as two-state variables.
    t_reading pending_readings[$];
    int       mismatch_count;
    int       readings_seen;
    int       quiet_cycles;
    int       gap_max;
    int       stall_max;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [CNT_W-1:0] reload_count();
        return CNT_W'(skip_q) + CNT_W'(AVG_SAMPLES_DEF);
    endfunction

    function automatic void reset_altimeter();
        skip_q      = SKIP_RST;
        floor_q     = FLOOR_RST;
        ceiling_q   = CEILING_RST;
        scale_q     = SCALE_RST;
        word_q      = '0;
        valid_q     = 1'b1;
        sum_q       = '0;
        offset_q    = '0;
        done_q      = 1'b0;
        countdown_q = reload_count();
    endfunction

    function automatic void apply_register(t_cfg_reg idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_SKIP:    skip_q    = data[SKIP_W-1:0];
            CFG_FLOOR:   floor_q   = data[WORD_W-1:0];
            CFG_CEILING: ceiling_q = data[WORD_W-1:0];
            CFG_SCALE:   scale_q   = data[SCALE_W-1:0];
            default: ;
        endcase
        countdown_q = reload_count();
    endfunction

    function automatic t_reading predict_reading(logic idle, logic [WORD_W-1:0] raw);
        t_reading         r;
        logic [SUM_W-1:0] quot;
        logic [31:0]      diff;
        r.altitude = '0;
        if (idle) begin
            word_q  = raw;
            valid_q = (raw != '0);
        end
        if (valid_q) begin
            if (!done_q) begin
                countdown_q = countdown_q - CNT_W'(1);
                if (countdown_q == '0) begin
                    quot = sum_q / SUM_W'(AVG_SAMPLES_DEF);
                    if (quot < SUM_W'(floor_q)) begin
                        quot = SUM_W'(floor_q);
                    end
                    // The ceiling is applied last, so it wins over a higher floor.
                    if (quot > SUM_W'(ceiling_q)) begin
                        quot = SUM_W'(ceiling_q);
                    end
                    offset_q = quot[WORD_W-1:0];
                    done_q   = 1'b1;
                end else if (countdown_q <= CNT_W'(AVG_SAMPLES_DEF)) begin
                    sum_q = sum_q + SUM_W'(word_q);
                end
            end
            if (done_q) begin
                diff       = 32'(offset_q) - 32'(word_q);
                r.altitude = ALT_W'(diff * 32'(scale_q));
            end
        end
        r.ok   = valid_q;
        r.done = done_q;
        r.word = word_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] reading %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, readings_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_tick(input logic idle, input logic [WORD_W-1:0] raw);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.bus_idle   <= idle;
        req_ch.raw_sample <= raw;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_readings.push_back(predict_reading(idle, raw));
    endtask

    // Lets every pending result arrive, then gives the pipeline time to empty.
    task automatic drain_readings();
        req_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return offset_q + WORD_W'($urandom_range(0, 64)) - WORD_W'(32);
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Straight after reset the held word is zero but still counts as valid.
    task automatic test_startup_word();
        gap_max   = 13;
        stall_max = 13;
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b0, 16'h0000);
        send_tick(1'b0, WORD_W'($urandom_range(0, 65535)));
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, 16'h1234);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'h8000);
        send_tick(1'b1, 16'h7FFF);
        drain_readings();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_SKIP, 16'h00FF);
        write_register(CFG_FLOOR, 16'hFFFF);
        write_register(CFG_CEILING, 16'h0000);
        write_register(CFG_SCALE, 16'h00FF);
        repeat (3) send_tick(1'($urandom_range(0, 1)), random_word());
        drain_readings();
        write_register(CFG_SKIP, 16'h0000);
        write_register(CFG_FLOOR, 16'h0000);
        write_register(CFG_CEILING, 16'hFFFF);
        write_register(CFG_SCALE, 16'h0000);
        repeat (3) send_tick(1'($urandom_range(0, 1)), random_word());
        drain_readings();
    endtask

    // Repeated reloads keep the block averaging until the 24-bit sum wraps.
    task automatic test_sum_wrap();
        t_cfg_reg          idx;
        logic [CFG_W-1:0]  data;
        logic [WORD_W-1:0] raw;
        for (int round = 0; round < 8; round++) begin
            gap_max   = (round % 2 == 1) ? 13 : 0;
            stall_max = (round % 3 == 0) ? 0 : 13;
            idx       = t_cfg_reg'(CFG_IDX_W'($urandom_range(0, 3)));
            data      = CFG_W'($urandom_range(0, 65535));
            if (round == 0 || idx == CFG_SKIP) begin
                write_register(CFG_SKIP, 16'h0000);
            end else begin
                write_register(idx, data);
            end
            while (countdown_q > CNT_W'(1)) begin
                raw = 16'hF000 | WORD_W'($urandom_range(0, 16'h0FFF));
                if ($urandom_range(0, 15) == 0) begin
                    raw = '0;
                end
                send_tick(1'($urandom_range(0, 7) != 0), raw);
            end
            drain_readings();
        end
    endtask

    task automatic test_calibration();
        gap_max   = 13;
        stall_max = 13;
        case ($urandom_range(0, 3))
            0: begin
                // Wide window: the quotient passes unchanged.
                write_register(CFG_FLOOR, 16'h0000);
                write_register(CFG_CEILING, 16'hFFFF);
            end
            1: begin
                write_register(CFG_FLOOR, 16'hFFFF);
                write_register(CFG_CEILING, 16'hFFFF);
            end
            2: begin
                write_register(CFG_FLOOR, 16'h0000);
                write_register(CFG_CEILING, CFG_W'($urandom_range(0, 1000)));
            end
            default: begin
                // Floor above ceiling.
                write_register(CFG_FLOOR, 16'hFFFF);
                write_register(CFG_CEILING, CFG_W'($urandom_range(0, 65534)));
            end
        endcase
        write_register(CFG_SCALE, CFG_W'(SCALE_RST));
        write_register(CFG_SKIP, CFG_W'($urandom_range(0, 6)));
        while (!done_q) begin
            send_tick(1'($urandom_range(0, 3) != 0), random_word());
        end
        drain_readings();
    endtask

    task automatic test_altitude();
        logic [SCALE_W-1:0] scales[6];
        t_cfg_reg           idx;
        scales = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(0, 255)), SCALE_RST,
                   8'($urandom_range(0, 255))};
        gap_max   = 13;
        stall_max = 13;
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, WORD_W'($urandom_range(0, 65535)));
        send_tick(1'b1, offset_q);
        send_tick(1'b1, 16'h0001);
        send_tick(1'b1, 16'hFFFF);
        drain_readings();
        for (int phase = 0; phase < 6; phase++) begin
            gap_max   = (phase % 2 == 0) ? 13 : 0;
            stall_max = (phase % 3 == 1) ? 0 : 13;
            write_register(CFG_SCALE, CFG_W'(scales[phase]));
            if (phase % 2 == 1) begin
                // Once calibrated these writes must leave the offset alone.
                idx = t_cfg_reg'(CFG_IDX_W'($urandom_range(0, 2)));
                write_register(idx, CFG_W'($urandom_range(0, 65535)));
            end
            repeat (12) send_tick(1'($urandom_range(0, 3) != 0), random_word());
            drain_readings();
        end
    endtask

    task automatic check_reading(input t_reading want);
        if (res_ch.altitude_cm !== want.altitude) begin
            report_mismatch("altitude_cm", res_ch.altitude_cm, want.altitude);
        end
        if (res_ch.sample_ok !== want.ok) begin
            report_mismatch("sample_ok", res_ch.sample_ok, want.ok);
        end
        if (res_ch.calibrated !== want.done) begin
            report_mismatch("calibrated", res_ch.calibrated, want.done);
        end
        if (res_ch.held_sample !== want.word) begin
            report_mismatch("held_sample", res_ch.held_sample, want.word);
        end
    endtask

    // Result side: random back-pressure, then compare with the oldest prediction.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            readings_seen++;
            if (pending_readings.size() == 0) begin
                report_mismatch("result with nothing pending", res_ch.held_sample, 0);
            end else begin
                check_reading(pending_readings.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("baro_offset_calibrate_convert test failed");
            $finish;
        end
    end

    initial begin
        gap_max        = 13;
        stall_max      = 13;
        reset_altimeter();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_SKIP;
        i_cfg_data        <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.bus_idle   <= 1'b0;
        req_ch.raw_sample <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_startup_word();
        test_register_extremes();
        test_sum_wrap();
        test_calibration();
        test_altitude();

        drain_readings();
        if (mismatch_count == 0) begin
            $display("baro_offset_calibrate_convert test passed");
        end else begin
            $display("baro_offset_calibrate_convert test failed");
        end
        $finish;
    end

endmodule
